>>> sv/mlpe2_pkg.sv
package mlpe2_pkg;

  // Fixed-point format of the weights, scaled inputs and activations.
  localparam int WFRAC      = 14;
  localparam int NUM_HIDDEN = 4;
  localparam int LANE_W     = 16;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // Exp2 fraction table.
  localparam int EXP2_N     = 64;
  localparam int EXP2_IDX_W = $clog2(EXP2_N);
  localparam int EXP2_W     = WFRAC + 1;

  // Scaled input widths.
  localparam int X0_W = 19;
  localparam int X1_W = 24;
  localparam int X2_W = 16;

  // Products, hidden preactivation, rounded magnitude, activation, output sum.
  localparam int PV_W   = X0_W + LANE_W;
  localparam int PH_W   = X1_W + LANE_W;
  localparam int PD_W   = X2_W + LANE_W;
  localparam int PRE_W  = PH_W + 2;
  localparam int MAG_W  = PRE_W - WFRAC;
  localparam int INT_W  = MAG_W - WFRAC;
  localparam int ACT_W  = WFRAC + 2;
  localparam int PO_W   = ACT_W + LANE_W;
  localparam int ACC_W  = PO_W + 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NET_ENABLED = 3'd0,
    REG_HW_VELOCITY = 3'd1,
    REG_HW_HEIGHT   = 3'd2,
    REG_HW_DIR      = 3'd3,
    REG_OUT_WEIGHTS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             net_enabled;
    logic [CFG_W-1:0] hw_velocity;
    logic [CFG_W-1:0] hw_height;
    logic [CFG_W-1:0] hw_direction;
    logic [CFG_W-1:0] out_weights;
  } cfg_t;

  typedef logic [NUM_HIDDEN-1:0][ACT_W-1:0] act_vec_t;

  // Exact division by a constant through a reciprocal multiply.
  // Velocity: round(v * 2^14 / 125) = floor((|v| * 2^15 + 125) / 250).
  localparam int          NUM0_W   = 26;
  localparam int          SHIFT0   = 34;
  localparam longint      RECIP0_L = ((64'd1 << SHIFT0) + 64'd249) / 64'd250;
  localparam logic [26:0] RECIP0   = 27'(RECIP0_L);
  localparam logic [NUM0_W-1:0] BIAS0 = 26'd125;

  // Height: round(d * 4 * 2^14 / 15) = floor((|d| * 2^17 + 15) / 30).
  localparam int          NUM1_W   = 27;
  localparam int          SHIFT1   = 32;
  localparam longint      RECIP1_L = ((64'd1 << SHIFT1) + 64'd29) / 64'd30;
  localparam logic [27:0] RECIP1   = 28'(RECIP1_L);
  localparam logic [NUM1_W-1:0] BIAS1 = 27'd15;

  typedef logic [EXP2_W-1:0] exp2_rom_t [EXP2_N];

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table of 2^-(j/EXP2_N) with WFRAC fraction bits, built from a Taylor
  // series of exp(-z) in Q30. Evaluated at elaboration only.
  function automatic exp2_rom_t build_exp2_rom();
    exp2_rom_t         rom;
    longint unsigned   z;
    longint unsigned   term;
    longint unsigned   q30_one;
    longint unsigned   ln2_q30;
    longint            sum;
    longint unsigned   sum_u;
    longint unsigned   kk;
    q30_one = 64'd1073741824;
    ln2_q30 = 64'd744261118;
    for (int j = 0; j < EXP2_N; j++) begin
      z    = (longint'(j) * ln2_q30 + longint'(EXP2_N >> 1)) >> EXP2_IDX_W;
      term = q30_one;
      sum  = longint'(q30_one);
      for (int k = 1; k <= 12; k++) begin
        kk   = longint'(k);
        term = udiv_u64((term * z) >> 30, kk);
        if ((k & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      sum_u  = longint'(sum);
      rom[j] = EXP2_W'((sum_u + (64'd1 << (29 - WFRAC))) >> (30 - WFRAC));
    end
    return rom;
  endfunction

  localparam exp2_rom_t EXP2_ROM = build_exp2_rom();

endpackage

>>> sv/mlpe2_cfg_regs.sv
module mlpe2_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mlpe2_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlpe2_pkg::CFG_W-1:0]          cfg_data,
  output mlpe2_pkg::cfg_t                      cfg
);
  import mlpe2_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NET_ENABLED: cfg_nxt.net_enabled  = cfg_data[0];
        REG_HW_VELOCITY: cfg_nxt.hw_velocity  = cfg_data;
        REG_HW_HEIGHT:   cfg_nxt.hw_height    = cfg_data;
        REG_HW_DIR:      cfg_nxt.hw_direction = cfg_data;
        REG_OUT_WEIGHTS: cfg_nxt.out_weights  = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/mlpe2_scale.sv
module mlpe2_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               vld,
  input  logic signed [10:0]                 velocity,
  input  logic [9:0]                         gap_bottom,
  input  logic [9:0]                         agent_bottom,
  input  logic signed [1:0]                  direction,
  output logic                               vld_o,
  output logic signed [mlpe2_pkg::X0_W-1:0]  x0,
  output logic signed [mlpe2_pkg::X1_W-1:0]  x1,
  output logic signed [mlpe2_pkg::X2_W-1:0]  x2
);
  import mlpe2_pkg::*;

  logic                      vel_neg;
  logic [10:0]               vel_mag;
  logic [NUM0_W-1:0]         num0;
  logic [NUM0_W+26:0]        prod0;
  logic [X0_W-2:0]           q0;
  logic signed [10:0]        diff;
  logic                      diff_neg;
  logic [9:0]                diff_mag;
  logic [NUM1_W-1:0]         num1;
  logic [NUM1_W+27:0]        prod1;
  logic [X1_W-2:0]           q1;

  logic                      vld_r;
  logic signed [X0_W-1:0]    x0_r;
  logic signed [X1_W-1:0]    x1_r;
  logic signed [X2_W-1:0]    x2_r;

  always_comb begin
    vel_neg  = velocity[10];
    vel_mag  = vel_neg ? 11'(-velocity) : 11'(velocity);
    num0     = {vel_mag, 15'd0} + BIAS0;
    prod0    = (NUM0_W+27)'(num0) * (NUM0_W+27)'(RECIP0);
    q0       = prod0[SHIFT0 +: X0_W-1];

    diff     = $signed({1'b0, gap_bottom}) - $signed({1'b0, agent_bottom});
    diff_neg = diff[10];
    diff_mag = diff_neg ? 10'(-diff) : 10'(diff);
    num1     = {diff_mag, 17'd0} + BIAS1;
    prod1    = (NUM1_W+28)'(num1) * (NUM1_W+28)'(RECIP1);
    q1       = prod1[SHIFT1 +: X1_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= vel_neg  ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
    x1_r <= diff_neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    x2_r <= {direction, {WFRAC{1'b0}}};
  end

  assign vld_o = vld_r;
  assign x0    = x0_r;
  assign x1    = x1_r;
  assign x2    = x2_r;

endmodule

>>> sv/mlpe2_hidden.sv
module mlpe2_hidden (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               vld,
  input  logic signed [mlpe2_pkg::X0_W-1:0]  x0,
  input  logic signed [mlpe2_pkg::X1_W-1:0]  x1,
  input  logic signed [mlpe2_pkg::X2_W-1:0]  x2,
  input  mlpe2_pkg::cfg_t                    cfg,
  output logic                               vld_o,
  output mlpe2_pkg::act_vec_t                h
);
  import mlpe2_pkg::*;

  // Stage A: weight products. Stage B: preactivation sum.
  // Stage C: magnitude rounded to WFRAC fraction bits. Stage D: activation.
  logic [3:0]                vld_r;
  logic signed [PV_W-1:0]    pv_r   [NUM_HIDDEN];
  logic signed [PH_W-1:0]    ph_r   [NUM_HIDDEN];
  logic signed [PD_W-1:0]    pd_r   [NUM_HIDDEN];
  logic signed [PRE_W-1:0]   pre_r  [NUM_HIDDEN];
  logic [MAG_W-1:0]          mag_r  [NUM_HIDDEN];
  logic [NUM_HIDDEN-1:0]     neg_r;
  act_vec_t                  h_r;

  logic [PRE_W-1:0]          abs_pre [NUM_HIDDEN];
  logic [PRE_W-1:0]          rnd_pre [NUM_HIDDEN];
  logic [INT_W-1:0]          int_part [NUM_HIDDEN];
  logic [EXP2_IDX_W-1:0]     tbl_idx [NUM_HIDDEN];
  logic [EXP2_W-1:0]         tbl_val [NUM_HIDDEN];
  logic [EXP2_W-1:0]         shifted [NUM_HIDDEN];
  logic [EXP2_W-1:0]         act_mag [NUM_HIDDEN];
  act_vec_t                  h_nxt;

  always_comb begin
    for (int k = 0; k < NUM_HIDDEN; k++) begin
      abs_pre[k]  = pre_r[k][PRE_W-1] ? PRE_W'(-pre_r[k]) : PRE_W'(pre_r[k]);
      rnd_pre[k]  = abs_pre[k] + (PRE_W'(1) << (WFRAC - 1));

      int_part[k] = mag_r[k][MAG_W-1:WFRAC];
      tbl_idx[k]  = mag_r[k][WFRAC-1 -: EXP2_IDX_W];
      tbl_val[k]  = EXP2_ROM[tbl_idx[k]];
      // The table entry shifts out completely once the integer part passes WFRAC.
      if (int_part[k] > INT_W'(WFRAC)) begin
        shifted[k] = '0;
      end else begin
        shifted[k] = tbl_val[k] >> int_part[k][$clog2(WFRAC+1)-1:0];
      end
      act_mag[k] = (EXP2_W'(1) << WFRAC) - shifted[k];
      h_nxt[k]   = neg_r[k] ? ACT_W'(-$signed({1'b0, act_mag[k]}))
                            : ACT_W'({1'b0, act_mag[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_HIDDEN; k++) begin
      pv_r[k]  <= x0 * $signed(cfg.hw_velocity[LANE_W*k +: LANE_W]);
      ph_r[k]  <= x1 * $signed(cfg.hw_height[LANE_W*k +: LANE_W]);
      pd_r[k]  <= x2 * $signed(cfg.hw_direction[LANE_W*k +: LANE_W]);
      pre_r[k] <= PRE_W'(pv_r[k]) + PRE_W'(ph_r[k]) + PRE_W'(pd_r[k]);
      mag_r[k] <= rnd_pre[k][PRE_W-1:WFRAC];
      neg_r[k] <= pre_r[k][PRE_W-1];
    end
    h_r <= h_nxt;
  end

  assign vld_o = vld_r[3];
  assign h     = h_r;

endmodule

>>> sv/mlpe2_output.sv
module mlpe2_output (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld,
  input  mlpe2_pkg::act_vec_t h,
  input  mlpe2_pkg::cfg_t     cfg,
  output logic                out_valid,
  output logic                out_act
);
  import mlpe2_pkg::*;

  logic [1:0]               vld_r;
  logic signed [PO_W-1:0]   po_r [NUM_HIDDEN];
  logic signed [ACC_W-1:0]  acc;
  logic                     act_r;

  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_HIDDEN; k++) begin
      acc = acc + ACC_W'(po_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_HIDDEN; k++) begin
      po_r[k] <= $signed(h[k]) * $signed(cfg.out_weights[LANE_W*k +: LANE_W]);
    end
    act_r <= cfg.net_enabled & ~acc[ACC_W-1];
  end

  assign out_valid = vld_r[1];
  assign out_act   = act_r;

endmodule

>>> sv/mlp_3x4x1_exp2_activation_core.sv
// Three-input, four-hidden, one-output perceptron that decides whether the
// agent should act on one sample.
// Input channel: a transaction is taken at every rising edge where start is
// high and busy is low. busy is always low, so a new sample may be offered
// in every cycle. The sample is in_velocity, in_gap_bottom, in_agent_bottom
// and in_direction.
// Result channel: out_valid is high for exactly one cycle per sample and
// out_act is valid in that cycle. The receiver cannot stall; results simply
// flow out of the pipeline in order.
// Throughput is one sample per cycle. The result passes through the pipeline
// registers in order: input scaling, weight products, hidden sum, rounding,
// the exp2 table lookup, output products and the final sign check.
// Configuration: cfg_we, cfg_index and cfg_data write one register per edge;
// unknown indexes are ignored. Write only while no transaction is in flight.
// Synchronous reset clears the pipeline valid bits and the configuration
// registers, which leaves the net disabled with zero weights.
module mlp_3x4x1_exp2_activation_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [10:0]                  in_velocity,
  input  logic [9:0]                          in_gap_bottom,
  input  logic [9:0]                          in_agent_bottom,
  input  logic signed [1:0]                   in_direction,
  output logic                                out_valid,
  output logic                                out_act,
  input  logic                                cfg_we,
  input  logic [mlpe2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlpe2_pkg::CFG_W-1:0]         cfg_data
);
  import mlpe2_pkg::*;

  cfg_t                    cfg;
  logic                    accept;
  logic                    scl_vld;
  logic signed [X0_W-1:0]  x0;
  logic signed [X1_W-1:0]  x1;
  logic signed [X2_W-1:0]  x2;
  logic                    hid_vld;
  act_vec_t                h;

  // The pipeline never stalls, so a transaction is always taken.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  mlpe2_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Velocity by 1/125 and height difference by 1/3.75, rounded to nearest.
  mlpe2_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .vld          (accept),
    .velocity     (in_velocity),
    .gap_bottom   (in_gap_bottom),
    .agent_bottom (in_agent_bottom),
    .direction    (in_direction),
    .vld_o        (scl_vld),
    .x0           (x0),
    .x1           (x1),
    .x2           (x2)
  );

  // Hidden layer with the odd exp2 activation.
  mlpe2_hidden u_hidden (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (scl_vld),
    .x0    (x0),
    .x1    (x1),
    .x2    (x2),
    .cfg   (cfg),
    .vld_o (hid_vld),
    .h     (h)
  );

  // Output unit: only the sign of the preactivation matters.
  mlpe2_output u_output (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (hid_vld),
    .h         (h),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_act   (out_act)
  );

endmodule

>>> sim/tb_mlp_3x4x1_exp2_activation_core.sv
`timescale 1ns / 1ps

// Testbench for the 3-4-1 perceptron core with the exp2 activation.
//
// A cycle-free predictor below recomputes the decision for every
// ACT_PREDICTED sample. It uses the same fixed-point steps as the block:
// input scaling, hidden sums and their rounding, the exp2 fraction table and
// the sign of the output sum. Each expectation is queued when its input
// transaction is accepted and is compared with the next result strobe. The
// block cannot stall its results, so outputs are sampled on the falling edge,
// where they are stable. Inputs change only at rising edges.
module tb_mlp_3x4x1_exp2_activation_core;
  import mlpe2_pkg::*;

  // Depth of the core pipeline, from the accepting edge to the edge that takes the result.
  localparam int PIPE_DEPTH   = 7;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_STEPS    = 22;
  localparam int SERIES_TERMS = 12;

  localparam longint          ONE_Q    = longint'(1) << WFRAC;
  localparam longint unsigned Q30_UNIT = 64'd1 << 30;
  localparam longint unsigned LN2_Q30  = 64'd744261118;

  // Register indexes above the last real register must be ignored.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = CFG_IDX_W'(REG_OUT_WEIGHTS) + 1'b1;
  localparam int                   SPARE_IDX_HI = (1 << CFG_IDX_W) - 1;

  // Weight settings used by the directed part.
  localparam int KEEP_CFG          = -1;
  localparam int PRESET_ZERO_ON    = 0;
  localparam int PRESET_MAX        = 1;
  localparam int PRESET_MIXED      = 2;
  localparam int PRESET_OFF_LOADED = 3;

  // Where the expected decision of a directed row comes from.
  typedef enum {ACT_PREDICTED, ACT_LOW, ACT_HIGH} act_source_t;

  typedef struct {
    logic signed [10:0] velocity;
    logic [9:0]         gap_bottom;
    logic [9:0]         agent_bottom;
    logic signed [1:0]  direction;
  } sample_t;

  typedef struct {
    int          preset;
    int          vel;
    int          gap;
    int          agent;
    int          dir;
    act_source_t src;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [10:0]     in_velocity = '0;
  logic [9:0]             in_gap_bottom = '0;
  logic [9:0]             in_agent_bottom = '0;
  logic signed [1:0]      in_direction = '0;
  logic                   out_valid;
  logic                   out_act;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Predictor state: the register copy and the 2^-(j/N) fraction table.
  cfg_t                   net_cfg = '0;
  longint unsigned        pow2_frac [EXP2_N];

  logic                   act_expected_q [$];
  int                     mismatches = 0;
  cfg_t                   presets [4];

  // Directed rows. A row with a preset first drains the pipeline and loads
  // that weight setting. The first rows run on the reset values, so the net
  // is disabled and every decision is low. With zero weights the output sum
  // is exactly zero, which counts as a high decision. Full-scale inputs drive
  // the hidden units into saturation, and a direction of binary 10 means -2.
  row_t directed_steps [NUM_STEPS] = '{
    '{KEEP_CFG,              0,    0,    0,  0, ACT_LOW},
    '{KEEP_CFG,          -1024, 1023,    0,  1, ACT_LOW},
    '{KEEP_CFG,           1023,    0, 1023, -1, ACT_LOW},
    '{PRESET_ZERO_ON,        0,    0,    0,  0, ACT_HIGH},
    '{KEEP_CFG,          -1024,    0, 1023, -2, ACT_HIGH},
    '{KEEP_CFG,           1023, 1023,    0,  1, ACT_HIGH},
    '{PRESET_MAX,         1023, 1023,    0,  1, ACT_PREDICTED},
    '{KEEP_CFG,          -1024,    0, 1023, -1, ACT_PREDICTED},
    '{KEEP_CFG,              0,    0,    0,  0, ACT_PREDICTED},
    '{KEEP_CFG,              1,    0,    0,  0, ACT_PREDICTED},
    '{KEEP_CFG,              0,    5,    4,  0, ACT_PREDICTED},
    '{KEEP_CFG,              0,    0,    0, -2, ACT_PREDICTED},
    '{KEEP_CFG,             -1,  512,  512,  0, ACT_PREDICTED},
    '{PRESET_MIXED,      -1024, 1023,    0,  1, ACT_PREDICTED},
    '{KEEP_CFG,           1023,    0, 1023, -2, ACT_PREDICTED},
    '{KEEP_CFG,              0,  300,  301,  0, ACT_PREDICTED},
    '{KEEP_CFG,            125,    0,    0, -1, ACT_PREDICTED},
    '{KEEP_CFG,            -63,    7,    3,  1, ACT_PREDICTED},
    '{KEEP_CFG,            512, 1023, 1023,  1, ACT_PREDICTED},
    '{PRESET_OFF_LOADED,  1023, 1023,    0,  1, ACT_LOW},
    '{KEEP_CFG,          -1024,    0, 1023, -2, ACT_LOW},
    '{KEEP_CFG,              0,    0,    0,  0, ACT_LOW}
  };

  mlp_3x4x1_exp2_activation_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_velocity     (in_velocity),
    .in_gap_bottom   (in_gap_bottom),
    .in_agent_bottom (in_agent_bottom),
    .in_direction    (in_direction),
    .out_valid       (out_valid),
    .out_act         (out_act),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The table entry j holds 2^-(j/N) with WFRAC fraction bits. It is a
  // truncated Taylor series of exp(-z) in Q30, rounded at the end.
  initial begin : build_pow2_table
    longint unsigned z;
    longint unsigned term;
    longint          series;
    for (int j = 0; j < EXP2_N; j++) begin
      z      = (longint'(j) * LN2_Q30 + EXP2_N / 2) / EXP2_N;
      term   = Q30_UNIT;
      series = longint'(Q30_UNIT);
      for (int k = 1; k <= SERIES_TERMS; k++) begin
        term = ((term * z) >> 30) / k;
        if (k % 2 == 1) begin
          series -= longint'(term);
        end else begin
          series += longint'(term);
        end
      end
      pow2_frac[j] = (longint'(series) + (64'd1 << (29 - WFRAC))) >> (30 - WFRAC);
    end
  end

  // Division rounded to nearest, ties away from zero; den is positive.
  function automatic longint round_half_away(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint weight_lane(logic [CFG_W-1:0] word, int k);
    return longint'($signed(word[LANE_W*k +: LANE_W]));
  endfunction

  // Odd activation: 1 - 2^-|x| carried with the sign of x. The integer part
  // of |x| shifts the table entry, so the value saturates at exactly one.
  function automatic longint exp2_squash(longint pre);
    longint unsigned m;
    longint unsigned whole;
    longint unsigned idx;
    longint unsigned mag;
    m     = (pre < 0) ? longint'(-pre) : pre;
    whole = m >> WFRAC;
    idx   = ((m & (ONE_Q - 1)) * EXP2_N) >> WFRAC;
    mag   = ONE_Q - ((whole >= 32) ? 0 : (pow2_frac[idx] >> whole));
    return (pre < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic predict_act(sample_t s);
    longint x_vel;
    longint x_hgt;
    longint x_dir;
    longint pre;
    longint acc;
    x_vel = round_half_away(longint'(s.velocity) * ONE_Q, 125);
    x_hgt = round_half_away((longint'(s.gap_bottom) - longint'(s.agent_bottom)) * 4 * ONE_Q,
                            15);
    x_dir = longint'(s.direction) * ONE_Q;
    acc   = 0;
    for (int k = 0; k < NUM_HIDDEN; k++) begin
      pre = x_vel * weight_lane(net_cfg.hw_velocity, k)
          + x_hgt * weight_lane(net_cfg.hw_height, k)
          + x_dir * weight_lane(net_cfg.hw_direction, k);
      acc += exp2_squash(round_half_away(pre, ONE_Q)) * weight_lane(net_cfg.out_weights, k);
    end
    return net_cfg.net_enabled && (acc >= 0);
  endfunction

  // Four signed lanes; the arithmetic shift keeps some weights small so that
  // the hidden units also work away from saturation.
  function automatic logic [CFG_W-1:0] draw_weights(int shift);
    logic [CFG_W-1:0]         w;
    logic signed [LANE_W-1:0] v;
    for (int k = 0; k < NUM_HIDDEN; k++) begin
      v = LANE_W'($urandom);
      w[LANE_W*k +: LANE_W] = v >>> shift;
    end
    return w;
  endfunction

  // A quarter of the samples keep the agent close to the gap bottom and
  // another quarter use a slow velocity, so the hidden sums stay moderate.
  function automatic sample_t draw_sample();
    sample_t s;
    s.gap_bottom = 10'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      s.agent_bottom = s.gap_bottom + 10'($urandom_range(0, 15)) - 10'd8;
    end else begin
      s.agent_bottom = 10'($urandom);
    end
    if ($urandom_range(0, 3) == 0) begin
      s.velocity = 11'($urandom_range(0, 63)) - 11'sd32;
    end else begin
      s.velocity = 11'($urandom);
    end
    s.direction = 2'($urandom);
    return s;
  endfunction

  // One register write per rising edge. The caller lowers the write enable
  // after its last write, so the enable is never dropped and raised again in
  // the same time step.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_NET_ENABLED: net_cfg.net_enabled  = data[0];
      REG_HW_VELOCITY: net_cfg.hw_velocity  = data;
      REG_HW_HEIGHT:   net_cfg.hw_height    = data;
      REG_HW_DIR:      net_cfg.hw_direction = data;
      REG_OUT_WEIGHTS: net_cfg.out_weights  = data;
      default: ;
    endcase
  endtask

  // Writes all five registers and then one spare index with random data,
  // which must not disturb anything. Only bit 0 of the enable word counts.
  task automatic load_weights(cfg_t c);
    logic [CFG_W-1:0] junk;
    junk    = {$urandom, $urandom};
    junk[0] = c.net_enabled;
    put_reg(REG_NET_ENABLED, junk);
    put_reg(REG_HW_VELOCITY, c.hw_velocity);
    put_reg(REG_HW_HEIGHT, c.hw_height);
    put_reg(REG_HW_DIR, c.hw_direction);
    put_reg(REG_OUT_WEIGHTS, c.out_weights);
    put_reg(CFG_IDX_W'($urandom_range(int'(SPARE_IDX_LO), SPARE_IDX_HI)), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // Stops offering samples and waits until every queued decision has come
  // back. Each transaction yields one result, so an empty queue means the
  // pipeline is idle.
  task automatic drain_results();
    start <= 1'b0;
    while (act_expected_q.size() != 0) @(posedge clk);
  endtask

  // Called at a rising edge. Holds start low for the drawn gap, offers the
  // sample and returns at the edge that accepts it. busy is sampled on the
  // falling edge before that edge. start is left high so that a following
  // transaction with no gap goes out back to back.
  task automatic send_sample(sample_t s, int gap, act_source_t src);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_velocity     <= s.velocity;
    in_gap_bottom   <= s.gap_bottom;
    in_agent_bottom <= s.agent_bottom;
    in_direction    <= s.direction;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    case (src)
      ACT_LOW:  act_expected_q.push_back(1'b0);
      ACT_HIGH: act_expected_q.push_back(1'b1);
      default:  act_expected_q.push_back(predict_act(s));
    endcase
  endtask

  // The result strobe lasts one cycle and ends at the next rising edge.
  always @(negedge clk) begin : check_results
    logic want;
    if (rst_n && out_valid !== 1'b0) begin
      if (act_expected_q.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, got act %b",
                 $time, out_act);
        mismatches++;
      end else begin
        want = act_expected_q.pop_front();
        if (out_act !== want) begin
          $display("%0t: act mismatch, expected %b, got %b", $time, want, out_act);
          mismatches++;
        end
      end
    end
  end

  initial begin
    sample_t s;
    cfg_t    c;
    bit      quiet;
    int      gap;

    presets[PRESET_ZERO_ON] = '{net_enabled: 1'b1, default: '0};
    presets[PRESET_MAX] = '{net_enabled:  1'b1,
                            hw_velocity:  {NUM_HIDDEN{16'h7fff}},
                            hw_height:    {NUM_HIDDEN{16'h7fff}},
                            hw_direction: {NUM_HIDDEN{16'h7fff}},
                            out_weights:  {NUM_HIDDEN{16'h7fff}}};
    presets[PRESET_MIXED] = '{net_enabled:  1'b1,
                              hw_velocity:  {NUM_HIDDEN{16'h8000}},
                              hw_height:    {16'h8000, 16'hffff, 16'h0001, 16'h7fff},
                              hw_direction: {16'h7fff, 16'h0000, 16'hc000, 16'h4000},
                              out_weights:  {16'hffff, 16'h0001, 16'h7fff, 16'h8000}};
    presets[PRESET_OFF_LOADED] = presets[PRESET_MAX];
    presets[PRESET_OFF_LOADED].net_enabled = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_STEPS; r++) begin
      if (directed_steps[r].preset != KEEP_CFG) begin
        drain_results();
        load_weights(presets[directed_steps[r].preset]);
      end
      s.velocity     = 11'(directed_steps[r].vel);
      s.gap_bottom   = 10'(directed_steps[r].gap);
      s.agent_bottom = 10'(directed_steps[r].agent);
      s.direction    = 2'(directed_steps[r].dir);
      send_sample(s, $urandom_range(0, 4), directed_steps[r].src);
    end

    // Random phases, each with its own weights. The first runs disabled and
    // the second with every weight at its most negative value. About a third
    // of the phases offer samples back to back with no gaps.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 1) begin
        c = '{net_enabled:  1'b1,
              hw_velocity:  {NUM_HIDDEN{16'h8000}},
              hw_height:    {NUM_HIDDEN{16'h8000}},
              hw_direction: {NUM_HIDDEN{16'h8000}},
              out_weights:  {NUM_HIDDEN{16'h8000}}};
      end else begin
        c.net_enabled  = (p != 0);
        c.hw_velocity  = draw_weights($urandom_range(0, 12));
        c.hw_height    = draw_weights($urandom_range(0, 12));
        c.hw_direction = draw_weights($urandom_range(0, 12));
        c.out_weights  = draw_weights($urandom_range(0, 12));
      end
      drain_results();
      load_weights(c);
      quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s   = draw_sample();
        gap = quiet ? 0 : $urandom_range(0, 4);
        send_sample(s, gap, ACT_PREDICTED);
      end
    end

    // Let the pipeline empty, then watch a little longer for stray strobes.
    drain_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && act_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout: a run that has not finished within this time counts as a failure.
  initial begin
    #400_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
sv/mlpe2_pkg.sv
sv/mlpe2_cfg_regs.sv
sv/mlpe2_scale.sv
sv/mlpe2_hidden.sv
sv/mlpe2_output.sv
sv/mlp_3x4x1_exp2_activation_core.sv
sim/tb_mlp_3x4x1_exp2_activation_core.sv
